[hw/rtl/brl_pkg.sv]
package brl_pkg;

   localparam int COORD_BITS    = 12;
   localparam int DEC_BITS      = COORD_BITS + 4;
   localparam int STRAIGHT_BITS = COORD_BITS + 2;
   localparam int WIN_BITS      = 13;
   localparam int COLOUR_BITS   = 24;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_STEP  = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_WINDOW_VALID = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_W       = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CLIP_H       = 2'd2;

   localparam logic [WIN_BITS-1:0] CLIP_W_RESET = 13'd640;
   localparam logic [WIN_BITS-1:0] CLIP_H_RESET = 13'd480;

   typedef struct packed {
      logic                            steep;
      logic                            downward;
      logic [COORD_BITS-1:0]           major_pos;
      logic [COORD_BITS-1:0]           minor_pos;
      logic [COORD_BITS-1:0]           major_end;
      logic signed [DEC_BITS-1:0]      decision;
      logic signed [DEC_BITS-1:0]      step_diag;
      logic [STRAIGHT_BITS-1:0]        step_straight;
   } line_setup_type;

endpackage

[hw/rtl/bresenham_line_rasterizer_core.sv]
// Bresenham line rasterizer. A start beat (req_type = 0) loads two endpoints and a colour
// and returns nothing; each step beat (req_type = 1) then returns one pixel of the line in
// window coordinates with its packed colour (blue low byte, red high byte), an
// inside_window flag for clipping against the clip width and height registers, and
// last_pixel on the final pixel. Step beats return nothing while no line is active or
// window_valid is 0.
// The line state advances at the input handshake with one add and compare, and the pixel
// lands in an output register, so one beat per cycle is sustained as long as rsp_ready
// keeps up. Write the window registers only while idle.
module bresenham_line_rasterizer_core
   import brl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [COORD_BITS-1:0]    req_start_x,
   input  logic [COORD_BITS-1:0]    req_start_y,
   input  logic [COORD_BITS-1:0]    req_end_x,
   input  logic [COORD_BITS-1:0]    req_end_y,
   input  logic [7:0]               req_red,
   input  logic [7:0]               req_green,
   input  logic [7:0]               req_blue,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COORD_BITS-1:0]    rsp_pixel_x,
   output logic [COORD_BITS-1:0]    rsp_pixel_y,
   output logic [COLOUR_BITS-1:0]   rsp_pixel_colour,
   output logic                     rsp_inside_window,
   output logic                     rsp_last_pixel,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // configuration
   logic                window_valid_ff;
   logic [WIN_BITS-1:0] clip_w_ff;
   logic [WIN_BITS-1:0] clip_h_ff;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic                csr_write;

   // line state
   logic                       line_active_ff, line_active_in;
   logic [COORD_BITS-1:0]      major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0]      minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0]      major_end_ff, major_end_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic signed [DEC_BITS-1:0] step_diag_ff, step_diag_in;
   logic [STRAIGHT_BITS-1:0]   step_straight_ff, step_straight_in;
   logic                       steep_ff, steep_in;
   logic                       downward_ff, downward_in;
   logic [COLOUR_BITS-1:0]     line_colour_ff, line_colour_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]   pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0]   pixel_y_ff, pixel_y_in;
   logic [COLOUR_BITS-1:0]  pixel_colour_ff;
   logic                    inside_ff, inside_in;
   logic                    last_ff, last_in;

   line_setup_type setup;
   logic           req_fire;
   logic           emit;

   brl_setup u_setup (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .setup   (setup)
   );

   // CSR port
   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_BITS-1:2];
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      unique case (csr_index)
         CSR_WINDOW_VALID: prdata = {{(CSR_DATA_BITS-1){1'b0}}, window_valid_ff};
         CSR_CLIP_W:       prdata = {{(CSR_DATA_BITS-WIN_BITS){1'b0}}, clip_w_ff};
         CSR_CLIP_H:       prdata = {{(CSR_DATA_BITS-WIN_BITS){1'b0}}, clip_h_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_valid_ff <= 1'b0;
         clip_w_ff       <= CLIP_W_RESET;
         clip_h_ff       <= CLIP_H_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_VALID: window_valid_ff <= pwdata[0];
            CSR_CLIP_W:       clip_w_ff       <= pwdata[WIN_BITS-1:0];
            CSR_CLIP_H:       clip_h_ff       <= pwdata[WIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // accept whenever the output register is free or being drained
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;
   assign emit      = req_fire & (req_type == REQ_STEP) & line_active_ff & window_valid_ff;

   always_comb begin
      line_active_in   = line_active_ff;
      major_pos_in     = major_pos_ff;
      minor_pos_in     = minor_pos_ff;
      major_end_in     = major_end_ff;
      decision_in      = decision_ff;
      step_diag_in     = step_diag_ff;
      step_straight_in = step_straight_ff;
      steep_in         = steep_ff;
      downward_in      = downward_ff;
      line_colour_in   = line_colour_ff;

      pixel_x_in = steep_ff ? minor_pos_ff : major_pos_ff;
      pixel_y_in = steep_ff ? major_pos_ff : minor_pos_ff;
      inside_in  = ({1'b0, pixel_x_in} < clip_w_ff) &&
                   ({1'b0, pixel_y_in} < clip_h_ff);
      last_in    = major_pos_ff == major_end_ff;

      if (req_fire && req_type == REQ_START) begin
         line_active_in   = 1'b1;
         major_pos_in     = setup.major_pos;
         minor_pos_in     = setup.minor_pos;
         major_end_in     = setup.major_end;
         decision_in      = setup.decision;
         step_diag_in     = setup.step_diag;
         step_straight_in = setup.step_straight;
         steep_in         = setup.steep;
         downward_in      = setup.downward;
         line_colour_in   = {req_red, req_green, req_blue};
      end else if (emit) begin
         if (decision_ff > 0) begin
            minor_pos_in = minor_pos_ff + 1'b1;
            decision_in  = decision_ff + step_diag_ff;
         end else begin
            decision_in  = decision_ff +
                           $signed({{(DEC_BITS-STRAIGHT_BITS){1'b0}}, step_straight_ff});
         end
         if (last_in) begin
            line_active_in = 1'b0;
         end else if (downward_ff) begin
            major_pos_in = major_pos_ff - 1'b1;
         end else begin
            major_pos_in = major_pos_ff + 1'b1;
         end
      end

      // hold the result until taken, load a new one on emit
      rsp_valid_in = emit | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff   <= 1'b0;
         major_pos_ff     <= '0;
         minor_pos_ff     <= '0;
         major_end_ff     <= '0;
         decision_ff      <= '0;
         step_diag_ff     <= '0;
         step_straight_ff <= '0;
         steep_ff         <= 1'b0;
         downward_ff      <= 1'b0;
         line_colour_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         line_active_ff   <= line_active_in;
         major_pos_ff     <= major_pos_in;
         minor_pos_ff     <= minor_pos_in;
         major_end_ff     <= major_end_in;
         decision_ff      <= decision_in;
         step_diag_ff     <= step_diag_in;
         step_straight_ff <= step_straight_in;
         steep_ff         <= steep_in;
         downward_ff      <= downward_in;
         line_colour_ff   <= line_colour_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pixel_x_ff      <= pixel_x_in;
         pixel_y_ff      <= pixel_y_in;
         pixel_colour_ff <= line_colour_ff;
         inside_ff       <= inside_in;
         last_ff         <= last_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_x       = pixel_x_ff;
   assign rsp_pixel_y       = pixel_y_ff;
   assign rsp_pixel_colour  = pixel_colour_ff;
   assign rsp_inside_window = inside_ff;
   assign rsp_last_pixel    = last_ff;

endmodule

[hw/rtl/brl_setup.sv]
module brl_setup
   import brl_pkg::*;
(
   input  logic [COORD_BITS-1:0] start_x,
   input  logic [COORD_BITS-1:0] start_y,
   input  logic [COORD_BITS-1:0] end_x,
   input  logic [COORD_BITS-1:0] end_y,
   output line_setup_type        setup
);

   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic                  steep;
   logic [COORD_BITS-1:0] a0, b0, a1, b1;
   logic [COORD_BITS-1:0] ma0, mb0, ma1, mb1;
   logic [COORD_BITS-1:0] dmin;
   logic [COORD_BITS-1:0] dmaj;
   logic [DEC_BITS-1:0]   dmin2;
   logic [DEC_BITS-1:0]   dmaj2;
   logic [DEC_BITS-1:0]   dmaj1;

   always_comb begin
      adx   = (end_x > start_x) ? end_x - start_x : start_x - end_x;
      ady   = (end_y > start_y) ? end_y - start_y : start_y - end_y;
      steep = ady > adx;

      // swap axes for steep lines so a is always the major axis
      a0 = steep ? start_y : start_x;
      b0 = steep ? start_x : start_y;
      a1 = steep ? end_y   : end_x;
      b1 = steep ? end_x   : end_y;

      // order endpoints so the minor axis increases
      if (b0 > b1) begin
         ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
      end else begin
         ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
      end

      dmin  = mb1 - mb0;
      dmaj  = (ma1 > ma0) ? ma1 - ma0 : ma0 - ma1;
      dmin2 = {{(DEC_BITS-COORD_BITS-1){1'b0}}, dmin, 1'b0};
      dmaj2 = {{(DEC_BITS-COORD_BITS-1){1'b0}}, dmaj, 1'b0};
      dmaj1 = {{(DEC_BITS-COORD_BITS){1'b0}}, dmaj};

      setup.steep         = steep;
      setup.downward      = ma1 < ma0;
      setup.major_pos     = ma0;
      setup.minor_pos     = mb0;
      setup.major_end     = ma1;
      setup.decision      = $signed(dmin2 - dmaj1);
      setup.step_diag     = $signed(dmin2 - dmaj2);
      setup.step_straight = {1'b0, dmin, 1'b0};
   end

endmodule
